// File: rtl/romu_pkg.sv
// ----------------------------------------------------------------------------
// romu_pkg
// shared types and constants for the romu duo jr generator with bounded draw
// ----------------------------------------------------------------------------
`default_nettype none

package romu_pkg;

  localparam logic [63:0] XP1       = 64'h9E3779B185EBCA87;
  localparam logic [63:0] XP2       = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] XP3       = 64'h165667B19E3779F9;
  localparam logic [63:0] XP4       = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] XP5       = 64'h27D4EB2F165667C5;
  localparam logic [63:0] XXH_KEY   = 64'h00000000A5B35705;
  localparam logic [63:0] HASH_INIT = XXH_KEY + XP5 + 64'd8;
  localparam logic [63:0] Y_MASK    = 64'h1234567890ABCDEF;
  localparam logic [63:0] ROMU_MUL  = 64'd15241094284759029579;
  localparam int unsigned ROMU_ROT  = 27;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_H_INIT,
    CMD_K1,
    CMD_K2,
    CMD_H1,
    CMD_H2,
    CMD_H3,
    CMD_TAKE,
    CMD_BND,
    CMD_BND_DONE,
    CMD_ADV,
    CMD_ADV_DONE,
    CMD_MOD,
    CMD_OUT
  } dp_op_e;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_RAW,
    SRC_REM
  } out_src_e;

  typedef struct packed {
    dp_op_e   op;
    out_src_e src;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic mod_done;
    logic reject;
  } dp_status_t;

  function automatic logic [63:0] rotl64(logic [63:0] v, int unsigned r);
    return (v << r) | (v >> (64 - r));
  endfunction

endpackage

`default_nettype wire

// File: rtl/romu_mul64.sv
// ----------------------------------------------------------------------------
// romu_mul64
// low 64 bits of a 64x64 product from three 32x32 partial products
// ----------------------------------------------------------------------------
`default_nettype none

module romu_mul64 (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic             done_o,
  output logic [63:0]      p_o
);

  logic [63:0] a_q, b_q, acc_q, acc_d;
  logic [1:0]  cnt_q;
  logic        busy_q, done_q;
  logic [31:0] ma, mb;
  logic [63:0] prod;

  always_comb begin
    case (cnt_q)
      2'd0:    begin ma = a_q[31:0];  mb = b_q[31:0];  end
      2'd1:    begin ma = a_q[63:32]; mb = b_q[31:0];  end
      default: begin ma = a_q[31:0];  mb = b_q[63:32]; end
    endcase
    prod = {32'd0, ma} * {32'd0, mb};
    if (cnt_q == 2'd0) begin
      acc_d = prod;
    end else begin
      acc_d = acc_q + {prod[31:0], 32'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd2) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

`default_nettype wire

// File: rtl/romu_mod64.sv
// ----------------------------------------------------------------------------
// romu_mod64
// restoring remainder of a 64-bit dividend by a 32-bit divisor, one bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module romu_mod64 (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      rem_o
);

  logic [63:0] dd_q;
  logic [31:0] dv_q, rem_q, rem_d;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] trial;

  always_comb begin
    trial = {rem_q, dd_q[63]};
    if (trial >= {1'b0, dv_q}) begin
      rem_d = 32'(trial - {1'b0, dv_q});
    end else begin
      rem_d = trial[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dd_q  <= dividend_i;
      dv_q  <= divisor_i;
      rem_q <= 32'd0;
    end else if (busy_q) begin
      dd_q  <= {dd_q[62:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// File: rtl/romu_dp.sv
// ----------------------------------------------------------------------------
// romu_dp
// datapath: seed, state words, bound, draw and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module romu_dp import romu_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic [31:0] limit_i,
  input  wire dp_cmd_t     cmd_i,
  output dp_status_t       status_o,
  output logic [63:0]      value_o
);

  logic [63:0] seed_q, x_q, y_q, h_q, r_q, bound_q, value_q;
  logic [31:0] lim_q;
  logic        mul_start, mul_done, mod_start, mod_done;
  logic [63:0] mul_a, mul_b, mul_p, mod_dd, t_k2, t_h1, t_h2, t_h3;
  logic [31:0] rem;

  assign t_k2 = rotl64(h_q ^ mul_p, 27);
  assign t_h1 = (mul_p + XP4) ^ ((mul_p + XP4) >> 33);
  assign t_h2 = mul_p ^ (mul_p >> 29);
  assign t_h3 = mul_p ^ (mul_p >> 32);

  always_comb begin
    mul_start = 1'b1;
    mul_a     = ROMU_MUL;
    mul_b     = y_q;
    unique case (cmd_i.op)
      CMD_H_INIT: begin mul_a = seed_q;              mul_b = XP2; end
      CMD_K1:     begin mul_a = rotl64(mul_p, 31);   mul_b = XP1; end
      CMD_K2:     begin mul_a = t_k2;                mul_b = XP1; end
      CMD_H1:     begin mul_a = t_h1;                mul_b = XP2; end
      CMD_H2:     begin mul_a = t_h2;                mul_b = XP3; end
      CMD_ADV:    begin mul_a = ROMU_MUL;            mul_b = y_q; end
      default:    mul_start = 1'b0;
    endcase
    mod_start = (cmd_i.op == CMD_BND) || (cmd_i.op == CMD_MOD);
    mod_dd    = (cmd_i.op == CMD_BND) ? '1 : r_q;
  end

  romu_mul64 u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  romu_mod64 u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dd),
    .divisor_i  (lim_q),
    .done_o     (mod_done),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= 64'd0;
    end else if (cfg_we_i) begin
      seed_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_H_INIT:   h_q <= HASH_INIT;
      CMD_K2:       h_q <= t_k2;
      CMD_H3: begin
        x_q <= t_h3;
        y_q <= t_h3 ^ Y_MASK;
      end
      CMD_TAKE:     lim_q <= limit_i;
      CMD_BND_DONE: bound_q <= ~64'd0 - {32'd0, rem};
      CMD_ADV: begin
        r_q <= x_q;
        y_q <= rotl64(y_q - x_q, ROMU_ROT);
      end
      CMD_ADV_DONE: x_q <= mul_p;
      CMD_OUT: begin
        case (cmd_i.src)
          SRC_RAW: value_q <= r_q;
          SRC_REM: value_q <= {32'd0, rem};
          default: value_q <= 64'd0;
        endcase
      end
      default: ;
    endcase
  end

  assign status_o.mul_done = mul_done;
  assign status_o.mod_done = mod_done;
  assign status_o.reject   = (r_q >= bound_q);
  assign value_o           = value_q;

endmodule

`default_nettype wire

// File: rtl/romu_ctrl.sv
// ----------------------------------------------------------------------------
// romu_ctrl
// sequencer for reseed hashing, draws, rejection and result handoff
// ----------------------------------------------------------------------------
`default_nettype none

module romu_ctrl import romu_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        in_valid_i,
  input  wire logic        req_type_i,
  input  wire logic [31:0] limit_i,
  input  wire logic        out_stall_i,
  input  wire dp_status_t  status_i,
  output dp_cmd_t          cmd_o,
  output logic             in_stall_o,
  output logic             out_valid_o
);

  typedef enum logic [14:0] {
    S_HINIT = 15'b000000000000001,
    S_HK1   = 15'b000000000000010,
    S_HK2   = 15'b000000000000100,
    S_HH1   = 15'b000000000001000,
    S_HH2   = 15'b000000000010000,
    S_HH3   = 15'b000000000100000,
    S_IDLE  = 15'b000000001000000,
    S_BND   = 15'b000000010000000,
    S_BNDW  = 15'b000000100000000,
    S_ADV   = 15'b000001000000000,
    S_ADVW  = 15'b000010000000000,
    S_CHK   = 15'b000100000000000,
    S_MODW  = 15'b001000000000000,
    S_OUT   = 15'b010000000000000,
    S_SPARE = 15'b100000000000000
  } state_e;

  state_e   state_q, state_d;
  logic     bounded_q, bounded_d, out_valid_q, out_valid_d, out_free;
  out_src_e src_q, src_d;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    bounded_d   = bounded_q;
    src_d       = src_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op    = CMD_NONE;
    cmd_o.src   = src_q;
    unique case (state_q)
      S_HINIT: begin cmd_o.op = CMD_H_INIT; state_d = S_HK1; end
      S_HK1:   if (status_i.mul_done) begin cmd_o.op = CMD_K1; state_d = S_HK2; end
      S_HK2:   if (status_i.mul_done) begin cmd_o.op = CMD_K2; state_d = S_HH1; end
      S_HH1:   if (status_i.mul_done) begin cmd_o.op = CMD_H1; state_d = S_HH2; end
      S_HH2:   if (status_i.mul_done) begin cmd_o.op = CMD_H2; state_d = S_HH3; end
      S_HH3:   if (status_i.mul_done) begin cmd_o.op = CMD_H3; state_d = S_IDLE; end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op  = CMD_TAKE;
          bounded_d = req_type_i;
          if (!req_type_i) begin
            state_d = S_ADV;
          end else if (limit_i <= 32'd1) begin
            src_d   = SRC_ZERO;
            state_d = S_OUT;
          end else begin
            state_d = S_BND;
          end
        end
      end
      S_BND:   begin cmd_o.op = CMD_BND; state_d = S_BNDW; end
      S_BNDW:  if (status_i.mod_done) begin cmd_o.op = CMD_BND_DONE; state_d = S_ADV; end
      S_ADV:   begin cmd_o.op = CMD_ADV; state_d = S_ADVW; end
      S_ADVW:  if (status_i.mul_done) begin cmd_o.op = CMD_ADV_DONE; state_d = S_CHK; end
      S_CHK: begin
        if (!bounded_q) begin
          src_d   = SRC_RAW;
          state_d = S_OUT;
        end else if (status_i.reject) begin
          state_d = S_ADV;
        end else begin
          cmd_o.op = CMD_MOD;
          state_d  = S_MODW;
        end
      end
      S_MODW: if (status_i.mod_done) begin src_d = SRC_REM; state_d = S_OUT; end
      S_OUT: begin
        if (out_free) begin
          cmd_o.op    = CMD_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // a seed write restarts the state load
    if (cfg_we_i) begin
      state_d = S_HINIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_HINIT;
      bounded_q   <= 1'b0;
      src_q       <= SRC_ZERO;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bounded_q   <= bounded_d;
      src_q       <= src_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/romu_prng_bounded_draw_unit.sv
// ----------------------------------------------------------------------------
// romu_prng_bounded_draw_unit
// romu duo jr generator with raw and unbiased bounded draws
// ----------------------------------------------------------------------------
// request channel: in_valid_i / in_stall_o carry req_type_i and limit_i.
// result channel: out_valid_o / out_stall_i carry value_o, one per request.
// a write on cfg_we_i loads a new seed and rehashes the state words.
// the multiplier serves the state load and the draws. a raw draw advances
// the state and returns the old x word; a limit of 0 or 1 gives zero with
// no draw; a bounded draw takes 2^64-1 minus (2^64-1 mod limit) as bound,
// redraws while the raw output is at or above it, then returns that output mod limit.
// one request is in work at a time; the result sits in an output register,
// so the next request is taken while the previous result is stalled.
// after reset a state load runs (xxh64 of the seed), and one runs after
// each seed write; requests are stalled meanwhile.
// a stalled result holds; a finished draw waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module romu_prng_bounded_draw_unit import romu_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        req_type_i,
  input  wire logic [31:0] limit_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      value_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  romu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .in_valid_i  (in_valid_i),
    .req_type_i  (req_type_i),
    .limit_i     (limit_i),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  romu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .limit_i     (limit_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .value_o     (value_o)
  );

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(status.mul_done && status.mod_done))
    else $error("multiplier and remainder unit finished together");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !cfg_we_i) |=> in_stall_o)
    else $error("request taken while another is in work");

  a_busy_after_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o)
    else $error("request channel open during state load");

endmodule

`default_nettype wire
